/* hw/rtl/tpq_pkg.sv */
// Shared types and constants for the timed print job queue.
// Used by tpq_cell and timed_print_job_queue; depends on nothing.
package tpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int PAGES_W = 10;
	localparam int TAG_W   = 16;
	localparam int IVL_W   = 16;
	localparam int TPP_W   = 10;
	localparam int REM_W   = 20;
	localparam int WAIT_W  = 5;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_PAGE   = 2'd1;

	typedef struct packed {
		logic [PAGES_W-1:0] pages;
		logic [TAG_W-1:0]   tag;
	} entry_t;

	typedef struct packed {
		logic pop;
		logic load_here;
		logic load_next;
	} cell_ctrl_t;

endpackage

/* hw/rtl/timed_print_job_queue.sv */
// Timed print job queue top level: slot timer, chain of queue cells, printer.
// Depends on tpq_pkg and tpq_cell.
// Each result beat is registered and shows in the cycle after its input beat.
// Throughput: one input beat per cycle; the output register stalls input only when full and m_axis_tready is low.
// Each tick updates the queue chain, the slot countdown and the print countdown at once.
// Reset: arst_n clears control state, the slot opens and the printer is idle.
module timed_print_job_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [0] job_offered, [10:1] job_pages, [26:11] job_tag
	input  logic [tpq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] job_accepted, [1] job_dropped, [2] print_finished, [18:3] finished_tag,
	// [19] print_started, [35:20] started_tag, [40:36] jobs_waiting, [41] printer_busy
	output logic [tpq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                             cfg_we,
	input  logic [tpq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tpq_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [tpq_pkg::IVL_W-1:0]    arrival_interval_q;
	logic [tpq_pkg::TPP_W-1:0]    ticks_per_page_q;
	logic [tpq_pkg::IVL_W-1:0]    slot_wait_q;
	logic [tpq_pkg::CNT_W-1:0]    count_q;
	logic                         busy_q;
	logic [tpq_pkg::REM_W-1:0]    rem_q;
	logic [tpq_pkg::TAG_W-1:0]    cur_tag_q;
	logic                         out_valid_q;
	logic [tpq_pkg::OUT_DATA_W-1:0] out_data_q;

	logic                         beat;
	logic                         offered;
	tpq_pkg::entry_t              in_entry;
	logic                         slot_open;
	logic                         push;
	logic                         dropped;
	logic [tpq_pkg::CNT_W-1:0]    count_pushed;
	logic                         finish;
	logic                         busy_after;
	logic                         start;
	tpq_pkg::entry_t              head;
	logic [tpq_pkg::REM_W-1:0]    start_rem;
	logic [tpq_pkg::CNT_W-1:0]    count_next;
	logic                         busy_next;
	logic [tpq_pkg::TAG_W-1:0]    fin_tag;
	logic [tpq_pkg::TAG_W-1:0]    st_tag;
	logic [31:0]                  count_ext;
	logic [tpq_pkg::OUT_DATA_W-1:0] result;

	tpq_pkg::entry_t              cell_entry [tpq_pkg::QUEUE_DEPTH];

	assign beat      = s_axis_tvalid && s_axis_tready;
	assign offered   = s_axis_tdata[0];
	assign in_entry.pages = s_axis_tdata[10:1];
	assign in_entry.tag   = s_axis_tdata[26:11];

	assign slot_open    = (slot_wait_q == '0);
	assign push         = slot_open && offered &&
		(count_q < tpq_pkg::CNT_W'(tpq_pkg::QUEUE_DEPTH));
	assign dropped      = slot_open && offered && !push;
	assign count_pushed = count_q + tpq_pkg::CNT_W'(push);

	assign finish     = busy_q && (rem_q <= tpq_pkg::REM_W'(1));
	assign busy_after = busy_q && !finish;
	assign start      = !busy_after && (count_pushed != '0);
	assign head       = (count_q == '0) ? in_entry : cell_entry[0];
	assign start_rem  = tpq_pkg::REM_W'(head.pages) * tpq_pkg::REM_W'(ticks_per_page_q);

	assign count_next = count_pushed - tpq_pkg::CNT_W'(start);
	assign busy_next  = busy_after || start;
	assign fin_tag    = finish ? cur_tag_q : '0;
	assign st_tag     = start ? head.tag : '0;
	assign count_ext  = 32'(count_next);

	assign result = {6'd0, busy_next, count_ext[tpq_pkg::WAIT_W-1:0], st_tag, start,
		fin_tag, finish, dropped, push};

	genvar gi;
	generate
		for (gi = 0; gi < tpq_pkg::QUEUE_DEPTH; gi++) begin : g_cell
			tpq_pkg::cell_ctrl_t ctrl;
			tpq_pkg::entry_t     nb;
			assign ctrl.pop       = beat && start;
			assign ctrl.load_here = beat && push && (count_q == tpq_pkg::CNT_W'(gi));
			assign ctrl.load_next = push && (count_q == tpq_pkg::CNT_W'(gi + 1));
			if (gi == tpq_pkg::QUEUE_DEPTH - 1) begin : g_last
				assign nb = '0;
			end else begin : g_mid
				assign nb = cell_entry[gi+1];
			end
			tpq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.new_entry (in_entry),
				.nb_entry  (nb),
				.entry     (cell_entry[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrival_interval_q <= tpq_pkg::IVL_W'(1);
			ticks_per_page_q   <= tpq_pkg::TPP_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tpq_pkg::REG_ARRIVAL_INTERVAL: arrival_interval_q <= cfg_data;
				tpq_pkg::REG_TICKS_PER_PAGE:   ticks_per_page_q   <= cfg_data[tpq_pkg::TPP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_wait_q <= '0;
			count_q     <= '0;
			busy_q      <= 1'b0;
			rem_q       <= '0;
			cur_tag_q   <= '0;
		end else if (beat) begin
			if (!slot_open) begin
				slot_wait_q <= slot_wait_q - tpq_pkg::IVL_W'(1);
			end else if (offered) begin
				slot_wait_q <= (arrival_interval_q == '0) ? '0 :
					arrival_interval_q - tpq_pkg::IVL_W'(1);
			end
			count_q <= count_next;
			busy_q  <= busy_next;
			if (start) begin
				rem_q     <= start_rem;
				cur_tag_q <= head.tag;
			end else if (finish) begin
				rem_q <= '0;
			end else if (busy_q) begin
				rem_q <= rem_q - tpq_pkg::REM_W'(1);
			end
		end
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (beat) begin
			out_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* hw/rtl/tpq_cell.sv */
// One queue cell: holds a job entry, loads a new job on a push and on a pop takes its neighbour or the new job.
// Depends on tpq_pkg.
module tpq_cell (
	input  logic               clk,
	input  tpq_pkg::cell_ctrl_t ctrl,
	input  tpq_pkg::entry_t    new_entry,
	input  tpq_pkg::entry_t    nb_entry,
	output tpq_pkg::entry_t    entry
);

	tpq_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			entry_q <= ctrl.load_next ? new_entry : nb_entry;
		end else if (ctrl.load_here) begin
			entry_q <= new_entry;
		end
	end

	assign entry = entry_q;

endmodule

/* hw/rtl/tpq_checker.sv */
// Port-level checks for timed_print_job_queue, bound to the top level.
// Depends on tpq_pkg.
module tpq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [tpq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	a_accept_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
		else $error("job both accepted and dropped");

	a_waiting_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[40:36] <= 5'(tpq_pkg::QUEUE_DEPTH)))
		else $error("jobs waiting beyond queue depth");

	a_fin_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[2]) |-> (m_axis_tdata[18:3] == '0))
		else $error("finished tag without finish");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[19]) |-> m_axis_tdata[41])
		else $error("printer idle after start");

	a_hold_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled beat changed");

endmodule

bind timed_print_job_queue tpq_checker u_tpq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* bench/timed_print_job_queue_test.sv */
// Self-checking bench for timed_print_job_queue: a cycle-true prediction of admission slots,
// queue overflow and printer timing is checked against every result beat.
// Depends on tpq_pkg and the timed_print_job_queue RTL.
module timed_print_job_queue_test;

	localparam logic [tpq_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [tpq_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int QUIET_LIMIT = 1000;
	localparam int TAIL_CYCLES = 4;

	typedef struct packed {
		logic [4:0]  pad;
		logic [15:0] tag;
		logic [9:0]  pages;
		logic        offered;
	} job_t;

	typedef struct packed {
		logic [5:0]  pad;
		logic        busy;
		logic [4:0]  waiting;
		logic [15:0] start_tag;
		logic        started;
		logic [15:0] finish_tag;
		logic        finished;
		logic        dropped;
		logic        accepted;
	} status_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [0] job_offered, [10:1] job_pages, [26:11] job_tag
	logic [tpq_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b1;
	// [0] job_accepted, [1] job_dropped, [2] print_finished, [18:3] finished_tag,
	// [19] print_started, [35:20] started_tag, [40:36] jobs_waiting, [41] printer_busy
	logic [tpq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [tpq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tpq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	bit src_gaps = 1'b1;
	bit sink_stalls = 1'b1;
	int mismatches = 0;
	int quiet_cycles = 0;
	int stall_left = 0;

	logic [15:0] slot_gap = 16'd1;
	logic [9:0]  page_ticks = 10'd1;
	logic [9:0]  fifo_pages [tpq_pkg::QUEUE_DEPTH];
	logic [15:0] fifo_tags [tpq_pkg::QUEUE_DEPTH];
	int          fifo_len = 0;
	logic [15:0] slot_left = '0;
	bit          printing = 1'b0;
	logic [15:0] printing_tag = '0;
	logic [19:0] ticks_left = '0;
	status_t     due_status [$];

	timed_print_job_queue u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic status_t print_tick(job_t j);
		status_t r;
		r = '0;
		if (slot_left != 0) begin
			slot_left = slot_left - 16'd1;
		end else if (j.offered) begin
			if (fifo_len < tpq_pkg::QUEUE_DEPTH) begin
				fifo_pages[fifo_len] = j.pages;
				fifo_tags[fifo_len] = j.tag;
				fifo_len++;
				r.accepted = 1'b1;
			end else begin
				r.dropped = 1'b1;
			end
			slot_left = (slot_gap == 0) ? 16'd0 : slot_gap - 16'd1;
		end
		if (printing) begin
			if (ticks_left <= 20'd1) begin
				ticks_left = '0;
				printing = 1'b0;
				r.finished = 1'b1;
				r.finish_tag = printing_tag;
			end else begin
				ticks_left = ticks_left - 20'd1;
			end
		end
		if (!printing && fifo_len != 0) begin
			printing_tag = fifo_tags[0];
			ticks_left = 20'(fifo_pages[0]) * 20'(page_ticks);
			for (int i = 0; i + 1 < fifo_len; i++) begin
				fifo_pages[i] = fifo_pages[i + 1];
				fifo_tags[i] = fifo_tags[i + 1];
			end
			fifo_len--;
			printing = 1'b1;
			r.started = 1'b1;
			r.start_tag = printing_tag;
		end
		r.waiting = 5'(fifo_len);
		r.busy = printing;
		return r;
	endfunction

	function automatic string show(status_t s);
		return $sformatf("acc=%0b drop=%0b fin=%0b/%h start=%0b/%h waiting=%0d busy=%0b pad=%h",
			s.accepted, s.dropped, s.finished, s.finish_tag, s.started, s.start_tag,
			s.waiting, s.busy, s.pad);
	endfunction

	task automatic send_job(input logic offered, input logic [9:0] pages, input logic [15:0] tag);
		job_t j;
		j = '0;
		j.offered = offered;
		j.pages = pages;
		j.tag = tag;
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= j;
		do @(posedge clk); while (!s_axis_tready);
		due_status.push_back(print_tick(j));
	endtask

	// keep offering the job until it is admitted, retrying on slot misses and drops
	task automatic admit_job(input logic [9:0] pages, input logic [15:0] tag);
		do send_job(1'b1, pages, tag); while (!due_status[$].accepted);
	endtask

	task automatic write_reg(input logic [tpq_pkg::CFG_IDX_W-1:0] idx,
			input logic [tpq_pkg::CFG_DATA_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (due_status.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tpq_pkg::REG_ARRIVAL_INTERVAL: slot_gap = value;
			tpq_pkg::REG_TICKS_PER_PAGE: page_ticks = value[9:0];
			default: ;
		endcase
	endtask

	task automatic test_fill_and_overflow();
		send_job(1'b0, 10'h2AA, 16'h5555);
		send_job(1'b1, 10'd0, 16'h0000);
		send_job(1'b1, 10'd20, 16'hFFFF);
		repeat (tpq_pkg::QUEUE_DEPTH + 1) send_job(1'b1, 10'd1, 16'($urandom));
	endtask

	task automatic test_zero_settings();
		write_reg(tpq_pkg::REG_ARRIVAL_INTERVAL, 16'h0000);
		write_reg(tpq_pkg::REG_TICKS_PER_PAGE, 16'h0000);
		repeat (3) send_job(1'b1, 10'h3FF, 16'($urandom));
		send_job(1'b0, 10'h155, 16'hAAAA);
		send_job(1'b1, 10'h000, 16'h0000);
		write_reg(REG_SPARE_2, 16'($urandom));
		write_reg(REG_SPARE_3, 16'($urandom));
		send_job(1'b1, 10'h3FF, 16'hFFFF);
		write_reg(tpq_pkg::REG_TICKS_PER_PAGE, 16'hFC01);
		repeat (3) send_job(1'b1, 10'd2, 16'($urandom));
	endtask

	task automatic test_mixed_traffic(input int beats, input logic [15:0] gap,
			input logic [15:0] per_page, input int offer_pct, input int pages_max);
		write_reg(tpq_pkg::REG_ARRIVAL_INTERVAL, gap);
		write_reg(tpq_pkg::REG_TICKS_PER_PAGE, per_page);
		repeat (beats)
			send_job($urandom_range(0, 99) < offer_pct, 10'($urandom_range(0, pages_max)),
				16'($urandom));
	endtask

	task automatic test_long_job();
		write_reg(tpq_pkg::REG_ARRIVAL_INTERVAL, 16'd1);
		write_reg(tpq_pkg::REG_TICKS_PER_PAGE, 16'd1);
		admit_job(10'd300, 16'($urandom));
		repeat (320) send_job($urandom_range(0, 99) < 60, 10'd0, 16'($urandom));
	endtask

	task automatic test_slow_slots();
		write_reg(tpq_pkg::REG_ARRIVAL_INTERVAL, 16'hFFFF);
		write_reg(tpq_pkg::REG_TICKS_PER_PAGE, 16'h03FF);
		admit_job(10'd1, 16'($urandom));
		repeat (180) send_job(1'($urandom), 10'($urandom), 16'($urandom));
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			if (stall_left == 0)
				m_axis_tready <= 1'b1;
		end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 13);
			m_axis_tready <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_results
		status_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_status.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result beat: %s", show(status_t'(m_axis_tdata)));
				mismatches++;
			end else begin
				want = due_status.pop_front();
				if (m_axis_tdata !== want) begin
					if (mismatches < 10)
						$display("result mismatch\n  expected %s\n  actual   %s",
							show(want), show(status_t'(m_axis_tdata)));
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_fill_and_overflow();
		test_zero_settings();
		test_mixed_traffic(80, 16'd1, 16'd1, 90, 3);
		test_mixed_traffic(80, 16'd3, 16'd2, 70, 4);
		test_mixed_traffic(80, 16'd2, 16'd5, 80, 2);
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		test_mixed_traffic(80, 16'd7, 16'd1, 60, 6);
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		test_mixed_traffic(80, 16'($urandom_range(1, 4)), 16'($urandom_range(1, 6)), 75, 5);
		test_mixed_traffic(80, 16'd1, 16'd3, 40, 2);
		test_long_job();
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		test_slow_slots();
		s_axis_tvalid <= 1'b0;
		while (due_status.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
